// ===== hw/rtl/sao_pkg.sv =====
// Shared types, constants and helpers for the straight-alpha over blender.
// No dependencies; every other file of the block imports this package.
package sao_pkg;

    localparam int CELL_COUNT = 8;
    localparam int CH_COUNT   = 3;

    localparam logic [7:0]  FULL_SCALE  = 8'd255;
    localparam logic [23:0] ROUND_HALF  = 24'd127;
    localparam logic [23:0] GLYPH_RESET = 24'hffffff;

    // One request in flight through the divider chain.
    typedef struct packed {
        logic                           zero;
        logic [31:0]                    dst;
        logic [7:0]                     oa;
        logic [CH_COUNT-1:0]            sat;
        logic [CH_COUNT-1:0][7:0]       rem;
        logic [CH_COUNT-1:0][7:0]       nlow;
        logic [CH_COUNT-1:0][7:0]       quo;
    } sao_div_t;

    // floor(x / 255) for x up to 255*255*255 + 127, the largest operand used: shift-add estimate, one correction step
    function automatic logic [15:0] div255_f(input logic [23:0] x);
        logic [24:0] sum;
        logic [16:0] q0;
        logic [24:0] prod;
        logic [24:0] r;
        sum  = {1'b0, x} + {9'b0, x[23:8]};
        q0   = sum[24:8];
        prod = {q0, 8'b0} - {8'b0, q0};
        r    = {1'b0, x} - prod;
        if (r >= 25'd255)
        begin
            q0 = q0 + 17'd1;
        end
        return q0[15:0];
    endfunction

endpackage

// ===== hw/rtl/sao_prep.sv =====
// Front end: alpha select, products, divide-by-255 terms, divider load.
// Depends on sao_pkg.
module sao_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [23:0]       glyph_color,
    input  logic [31:0]       dest_pixel,
    input  logic [31:0]       source_pixel,
    input  logic              glyph_mode,
    output logic              head_valid,
    output sao_pkg::sao_div_t head_data
);
    import sao_pkg::*;

    // stage 1
    logic [7:0]                src_a;
    logic [23:0]               src_rgb;
    logic                      s1_valid_reg;
    logic                      s1_zero_reg;
    logic [7:0]                s1_a_reg;
    logic [7:0]                s1_na_reg;
    logic [31:0]               s1_dst_reg;
    logic [23:0]               s1_rgb_reg;
    logic [15:0]               s1_t_reg;
    logic [CH_COUNT-1:0][15:0] s1_dd_reg;
    logic [CH_COUNT-1:0][15:0] s1_dd_next;

    // stage 2
    logic [15:0]               oa_div;
    logic [7:0]                s2_oa_next;
    logic [CH_COUNT-1:0][23:0] s2_p_next;
    logic [CH_COUNT-1:0][15:0] s2_sa_next;
    logic                      s2_valid_reg;
    logic                      s2_zero_reg;
    logic [31:0]               s2_dst_reg;
    logic [7:0]                s2_oa_reg;
    logic [CH_COUNT-1:0][23:0] s2_p_reg;
    logic [CH_COUNT-1:0][15:0] s2_sa_reg;

    // stage 3 (divider load)
    logic [CH_COUNT-1:0][15:0] pdiv;
    logic [CH_COUNT-1:0][16:0] num;
    sao_div_t                  head_next;
    logic                      head_valid_reg;
    sao_div_t                  head_reg;

    always_comb
    begin
        logic [7:0] mx;
        mx = source_pixel[23:16];
        if (source_pixel[15:8] > mx)
        begin
            mx = source_pixel[15:8];
        end
        if (source_pixel[7:0] > mx)
        begin
            mx = source_pixel[7:0];
        end
        if (glyph_mode)
        begin
            src_a   = mx;
            src_rgb = glyph_color;
        end
        else
        begin
            src_a   = source_pixel[31:24];
            src_rgb = source_pixel[23:0];
        end
        for (int c = 0; c < CH_COUNT; c++)
        begin
            s1_dd_next[c] = dest_pixel[c*8 +: 8] * dest_pixel[31:24];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_zero_reg <= (src_a == 8'd0);
        s1_a_reg    <= src_a;
        s1_na_reg   <= FULL_SCALE - src_a;
        s1_dst_reg  <= dest_pixel;
        s1_rgb_reg  <= src_rgb;
        s1_t_reg    <= dest_pixel[31:24] * (FULL_SCALE - src_a);
        s1_dd_reg   <= s1_dd_next;
    end

    always_comb
    begin
        oa_div     = div255_f({8'b0, s1_t_reg} + ROUND_HALF);
        s2_oa_next = s1_a_reg + oa_div[7:0];
        for (int c = 0; c < CH_COUNT; c++)
        begin
            s2_p_next[c]  = s1_dd_reg[c] * s1_na_reg;
            s2_sa_next[c] = s1_rgb_reg[c*8 +: 8] * s1_a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_zero_reg <= s1_zero_reg;
        s2_dst_reg  <= s1_dst_reg;
        s2_oa_reg   <= s2_oa_next;
        s2_p_reg    <= s2_p_next;
        s2_sa_reg   <= s2_sa_next;
    end

    // numerator carries the oa/2 rounding term; sat when quotient would pass 255
    always_comb
    begin
        head_next      = '0;
        head_next.zero = s2_zero_reg;
        head_next.dst  = s2_dst_reg;
        head_next.oa   = s2_oa_reg;
        for (int c = 0; c < CH_COUNT; c++)
        begin
            pdiv[c] = div255_f(s2_p_reg[c] + ROUND_HALF);
            num[c]  = {1'b0, s2_sa_reg[c]} + {1'b0, pdiv[c]} + {10'b0, s2_oa_reg[7:1]};
            head_next.sat[c]  = (num[c][16:8] >= {1'b0, s2_oa_reg});
            head_next.rem[c]  = num[c][15:8];
            head_next.nlow[c] = num[c][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

    assign head_valid = head_valid_reg;
    assign head_data  = head_reg;

endmodule

// ===== hw/rtl/sao_div_cell.sv =====
// One restoring-division step: one quotient bit for each color channel.
// Depends on sao_pkg.
module sao_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              prev_valid,
    input  sao_pkg::sao_div_t prev_data,
    output logic              valid,
    output sao_pkg::sao_div_t data
);
    import sao_pkg::*;

    sao_div_t data_next;
    logic     valid_reg;
    sao_div_t data_reg;

    always_comb
    begin
        logic [8:0] trial;
        logic       ge;
        data_next = prev_data;
        for (int c = 0; c < CH_COUNT; c++)
        begin
            trial = {prev_data.rem[c], prev_data.nlow[c][7]};
            ge    = (trial >= {1'b0, prev_data.oa});
            if (ge)
            begin
                trial = trial - {1'b0, prev_data.oa};
            end
            data_next.rem[c]  = trial[7:0];
            data_next.nlow[c] = {prev_data.nlow[c][6:0], 1'b0};
            data_next.quo[c]  = {prev_data.quo[c][6:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== hw/rtl/straight_alpha_over_blend_top.sv =====
// Top level of the straight-alpha over blender: front end, divider cell row, result register.
// Depends on sao_pkg, sao_prep and sao_div_cell.
//
// Usage:
//   Request channel: drive dest_pixel, source_pixel and glyph_mode with start high.
//   busy is always low, so a request is taken at every edge where start is high;
//   one pixel per clock sustained.
//   Result channel: done pulses for one cycle with blended_pixel and written. The
//   request passes three front-end stages (alpha select and 8x8 products, 16x8
//   products and oa, divide-by-255 terms), eight divider cells (one quotient bit
//   each, all three channels side by side), then the result register. There is no
//   back-pressure: the receiver takes every result in the cycle it is shown.
//   Config: glyph_color_we writes glyph_color_wdata into the glyph color register;
//   write only while no request is in flight.
//   Reset: clears all valid bits (nothing in flight, done low) and sets the
//   glyph color to white.
//   Zero source alpha passes dest_pixel through with written low.
module straight_alpha_over_blend_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] dest_pixel,
    input  logic [31:0] source_pixel,
    input  logic        glyph_mode,
    input  logic        glyph_color_we,
    input  logic [23:0] glyph_color_wdata,
    output logic        done,
    output logic [31:0] blended_pixel,
    output logic        written
);
    import sao_pkg::*;

    // glyph color register
    logic [23:0] glyph_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_color_reg <= GLYPH_RESET;
        end
        else if (glyph_color_we)
        begin
            glyph_color_reg <= glyph_color_wdata;
        end
    end

    // fully pipelined, never stalls
    assign busy = 1'b0;

    // front end feeds the head of the divider row
    logic                 cell_valid [CELL_COUNT+1];
    sao_div_t             cell_data  [CELL_COUNT+1];

    sao_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .glyph_color  (glyph_color_reg),
        .dest_pixel   (dest_pixel),
        .source_pixel (source_pixel),
        .glyph_mode   (glyph_mode),
        .head_valid   (cell_valid[0]),
        .head_data    (cell_data[0])
    );

    // row of division cells, MSB of the quotient first
    for (genvar i = 0; i < CELL_COUNT; i++)
    begin : g_cell
        sao_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .prev_valid (cell_valid[i]),
            .prev_data  (cell_data[i]),
            .valid      (cell_valid[i+1]),
            .data       (cell_data[i+1])
        );
    end

    // result assembly: saturate each channel, alpha-zero passes destination
    sao_div_t    tail;
    logic [31:0] pixel_next;
    logic        done_reg;
    logic [31:0] blended_pixel_reg;
    logic        written_reg;

    assign tail = cell_data[CELL_COUNT];

    always_comb
    begin
        pixel_next = {tail.oa, 24'b0};
        for (int c = 0; c < CH_COUNT; c++)
        begin
            pixel_next[c*8 +: 8] = tail.sat[c] ? FULL_SCALE : tail.quo[c];
        end
        if (tail.zero)
        begin
            pixel_next = tail.dst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cell_valid[CELL_COUNT];
        end
    end

    always_ff @(posedge clk)
    begin
        blended_pixel_reg <= pixel_next;
        written_reg       <= !tail.zero;
    end

    assign done          = done_reg;
    assign blended_pixel = blended_pixel_reg;
    assign written       = written_reg;

    // a request leaving the cell row shows up as a result on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[CELL_COUNT] |=> done)
        else $error("result strobe missing after divider row");

    // output alpha is at least the nonzero source alpha
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && written) |-> (blended_pixel[31:24] != 8'd0))
        else $error("written pixel with zero output alpha");

    // restoring division leaves a remainder below the divisor on unsaturated channels
    assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid[CELL_COUNT] && !tail.zero) |->
            ((tail.sat[0] || (tail.rem[0] < tail.oa)) &&
             (tail.sat[1] || (tail.rem[1] < tail.oa)) &&
             (tail.sat[2] || (tail.rem[2] < tail.oa))))
        else $error("divider remainder out of range");

endmodule

// ===== test/tb.sv =====
// Self-checking bench for straight_alpha_over_blend_top: straight-alpha "over" per pixel.
// Needs only the block's RTL; the expected pixels come from a behavioral model held here.
module tb;

    // Arithmetic constants of the blend equations.
    localparam int unsigned OPAQUE     = 255;
    localparam int unsigned ROUND_BIAS = 127;
    localparam logic [23:0] WHITE_RGB  = 24'hffffff;

    // Request edge to result edge through the block's pipeline.
    localparam int LATENCY = 12;

    // Alpha source select on glyph_mode.
    localparam logic MODE_NORMAL = 1'b0;
    localparam logic MODE_GLYPH  = 1'b1;

    // Only this many mismatches are printed; the rest are counted.
    localparam int REPORT_LIMIT = 10;

    // One expected result, with the request that caused it for the error report.
    typedef struct {
        logic [31:0] pixel;
        logic        written;
        logic [31:0] dst;
        logic [31:0] src;
        logic        glyph;
    } blend_expect_t;

    // Scoreboard: keeps its own copy of the glyph color, computes the composite for
    // every accepted request and compares results against them in order.
    class blend_scoreboard;
        blend_expect_t awaited[$];
        logic [23:0]   glyph_rgb;
        int            errors;
        int            n_requests;
        int            n_glyph;
        int            n_clear;
        int            n_results;
        int            n_colors;

        function new();
            glyph_rgb  = WHITE_RGB;
            errors     = 0;
            n_requests = 0;
            n_glyph    = 0;
            n_clear    = 0;
            n_results  = 0;
            n_colors   = 0;
        endfunction

        function void set_color(logic [23:0] rgb);
            glyph_rgb = rgb;
            n_colors++;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Porter-Duff over with straight alpha on both sides.
        function blend_expect_t composite_over(logic [31:0] dst, logic [31:0] src,
                                               logic glyph);
            blend_expect_t r;
            int unsigned   a;
            int unsigned   da;
            int unsigned   oa;
            int unsigned   s;
            int unsigned   d;
            int unsigned   prem;
            int unsigned   ch;
            logic [23:0]   colour;
            r.dst   = dst;
            r.src   = src;
            r.glyph = glyph;
            if (glyph == MODE_GLYPH)
            begin
                // coverage is the largest color byte, top byte unused
                a = src[23:16];
                if (src[15:8] > a)
                    a = src[15:8];
                if (src[7:0] > a)
                    a = src[7:0];
                colour = glyph_rgb;
            end
            else
            begin
                a      = src[31:24];
                colour = src[23:0];
            end
            if (a == 0)
            begin
                r.pixel   = dst;
                r.written = 1'b0;
                return r;
            end
            da = dst[31:24];
            oa = a + (da * (OPAQUE - a) + ROUND_BIAS) / OPAQUE;
            r.pixel[31:24] = oa[7:0];
            for (int i = 0; i < 3; i++)
            begin
                s    = colour[i*8 +: 8];
                d    = dst[i*8 +: 8];
                prem = s * a + (d * da * (OPAQUE - a) + ROUND_BIAS) / OPAQUE;
                ch   = (prem + oa / 2) / oa;
                if (ch > OPAQUE)
                    ch = OPAQUE;
                r.pixel[i*8 +: 8] = ch[7:0];
            end
            r.written = 1'b1;
            return r;
        endfunction

        function void note_request(logic [31:0] dst, logic [31:0] src, logic glyph);
            blend_expect_t e;
            e = composite_over(dst, src, glyph);
            awaited.push_back(e);
            n_requests++;
            if (glyph == MODE_GLYPH)
                n_glyph++;
            if (!e.written)
                n_clear++;
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("ERROR %s", what);
        endfunction

        function void check_result(logic [31:0] pixel, logic written);
            blend_expect_t want;
            n_results++;
            if (awaited.size() == 0)
            begin
                flag($sformatf("result %h/%b with no request outstanding", pixel, written));
                return;
            end
            want = awaited.pop_front();
            if (pixel !== want.pixel)
                flag($sformatf("blended_pixel expected %h got %h (dst %h src %h glyph %b)",
                               want.pixel, pixel, want.dst, want.src, want.glyph));
            if (written !== want.written)
                flag($sformatf("written expected %b got %b (dst %h src %h glyph %b)",
                               want.written, written, want.dst, want.src, want.glyph));
        endfunction
    endclass

    // Every input has a known value from time zero; reset starts asserted.
    logic        clk               = 1'b0;
    logic        rst_n             = 1'b0;
    logic        start             = 1'b0;
    logic [31:0] dest_pixel        = '0;
    logic [31:0] source_pixel      = '0;
    logic        glyph_mode        = MODE_NORMAL;
    logic        glyph_color_we    = 1'b0;
    logic [23:0] glyph_color_wdata = '0;
    logic        busy;
    logic        done;
    logic [31:0] blended_pixel;
    logic        written;

    blend_scoreboard sb = new();

    straight_alpha_over_blend_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .dest_pixel        (dest_pixel),
        .source_pixel      (source_pixel),
        .glyph_mode        (glyph_mode),
        .glyph_color_we    (glyph_color_we),
        .glyph_color_wdata (glyph_color_wdata),
        .done              (done),
        .blended_pixel     (blended_pixel),
        .written           (written)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Monitor. Stimulus changes by NBA at the edge, so everything read here is the
    // value that the block itself sees at this edge. The request is noted before the
    // result is checked, so a result can never be checked before its expectation exists.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (glyph_color_we)
                sb.set_color(glyph_color_wdata);
            if (start && !busy)
                sb.note_request(dest_pixel, source_pixel, glyph_mode);
            if (done)
                sb.check_result(blended_pixel, written);
        end
    end

    // Alpha byte biased toward the corners of the blend: clear, opaque, nearly either.
    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(1, 3));
            3: return 8'($urandom_range(252, 254));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Present one request and hold it until the block takes it. Before it, the
    // sender idles each cycle with probability idle_pct percent. start is only
    // lowered in idle cycles, so back-to-back requests keep it high throughout.
    task automatic send_request(logic [31:0] dst, logic [31:0] src, logic glyph,
                                int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        dest_pixel   <= dst;
        source_pixel <= src;
        glyph_mode   <= glyph;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stop sending and wait until every outstanding request has returned its result.
    // Checked at the falling edge so the monitor has already run for the rising one.
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Glyph color update; only called with nothing in flight.
    task automatic write_glyph_color(logic [23:0] rgb);
        glyph_color_we    <= 1'b1;
        glyph_color_wdata <= rgb;
        @(posedge clk);
        glyph_color_we    <= 1'b0;
    endtask

    // Edge cases first, all under the reset glyph color (white).
    task automatic directed_requests();
        // zero source alpha: destination passes through, written low
        send_request(32'h80102030, 32'h00123456, MODE_NORMAL, 0);
        send_request(32'h55aa55aa, 32'h00ffffff, MODE_NORMAL, 0);
        // opaque source, empty and full destination
        send_request(32'h00000000, 32'hffffffff, MODE_NORMAL, 0);
        send_request(32'hffffffff, 32'hff000000, MODE_NORMAL, 0);
        // faintest source over opaque and over clear destinations
        send_request(32'hffffffff, 32'h01000000, MODE_NORMAL, 0);
        send_request(32'h00ffffff, 32'h01ffffff, MODE_NORMAL, 0);
        send_request(32'hff000000, 32'h01ffffff, MODE_NORMAL, 0);
        // bright over bright at partial alphas: where channel rounding can pass 255
        send_request(32'h80ffffff, 32'h80ffffff, MODE_NORMAL, 0);
        send_request(32'hfeffffff, 32'h02ffffff, MODE_NORMAL, 0);
        send_request(32'h01ffffff, 32'hfeffffff, MODE_NORMAL, 0);
        send_request(32'h7fff00ff, 32'hfe00ff00, MODE_NORMAL, 0);
        send_request(32'hffffffff, 32'h7fffffff, MODE_NORMAL, 0);
        // glyph: no coverage, and a set top byte that must be ignored
        send_request(32'hc0112233, 32'h00000000, MODE_GLYPH, 0);
        send_request(32'hc0112233, 32'hff000000, MODE_GLYPH, 0);
        // glyph: each channel alone at full coverage
        send_request(32'h00000000, 32'h00ff0000, MODE_GLYPH, 0);
        send_request(32'h00000000, 32'h0000ff00, MODE_GLYPH, 0);
        send_request(32'h00000000, 32'h000000ff, MODE_GLYPH, 0);
        // glyph: minimal, mixed and full coverage
        send_request(32'hff000000, 32'h5a010000, MODE_GLYPH, 0);
        send_request(32'hff123456, 32'ha5408020, MODE_GLYPH, 0);
        send_request(32'hffffffff, 32'h00ffffff, MODE_GLYPH, 0);
        send_request(32'hffffffff, 32'hffffffff, MODE_GLYPH, 0);
        send_request(32'h01000000, 32'h00010101, MODE_GLYPH, 0);
    endtask

    // Random pixels: about a third in glyph mode, alphas biased toward the extremes.
    task automatic random_requests(int count, int idle_pct);
        logic [31:0] dst;
        logic [31:0] src;
        logic        glyph;
        for (int n = 0; n < count; n++)
        begin
            dst        = $urandom;
            src        = $urandom;
            dst[31:24] = pick_alpha();
            glyph      = ($urandom_range(2) == 0) ? MODE_GLYPH : MODE_NORMAL;
            if (glyph == MODE_GLYPH)
            begin
                case ($urandom_range(3))
                    0: src[23:0] = '0;
                    1: src[23:0] = {pick_alpha(), pick_alpha(), pick_alpha()};
                    default: ;
                endcase
            end
            else
            begin
                src[31:24] = pick_alpha();
            end
            send_request(dst, src, glyph, idle_pct);
        end
    endtask

    // Main sequence: reset, directed cases, then four random phases with sender idling
    // of 0, 79, 33 and 0 percent and new glyph colors. Each phase boundary drains the pipe
    // fully before the color write, which also gives the full pause in request traffic.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();

        drain();
        write_glyph_color(24'h000000);
        random_requests(150, 0);

        drain();
        write_glyph_color(WHITE_RGB);
        random_requests(150, 79);

        drain();
        write_glyph_color(24'($urandom));
        random_requests(150, 33);

        drain();
        write_glyph_color(24'($urandom));
        random_requests(150, 0);

        drain();
        // anything arriving now would be a result nobody asked for
        repeat (LATENCY + 4) @(posedge clk);

        $display("Covered %0d requests (%0d glyph mode, %0d with zero alpha) over %0d glyph colors.",
                 sb.n_requests, sb.n_glyph, sb.n_clear, sb.n_colors + 1);
        $display("Checked %0d results, %0d mismatches.", sb.n_results, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: allows far more time than a correct run needs.
    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sao_pkg.sv
hw/rtl/sao_prep.sv
hw/rtl/sao_div_cell.sv
hw/rtl/straight_alpha_over_blend_top.sv
test/tb.sv
